/* hdl/aunp_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// aunp_pkg
// Shared types, character codes and digit decode for the ASCII unsigned
// number parser.
// ---------------------------------------------------------------------------
package aunp_pkg;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 16;
    localparam int RADIX_W  = 5;
    localparam int OUT_W    = VALUE_W + OFFSET_W;

    // register reset value
    localparam logic [RADIX_W-1:0] RADIX_MODE_RST = 5'd0;

    // radix codes
    localparam logic [RADIX_W-1:0] RADIX_AUTO = 5'd0;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 5'd16;

    // digit code for a character that is no digit at all (not below any radix)
    localparam logic [RADIX_W-1:0] NO_DIGIT = 5'h1F;

    // character codes
    localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LX = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX = 8'h58;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    // parse phases
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_ZERO   = 2'd2,
        PH_PREFIX = 2'd3
    } t_phase;

    // value of a hex/decimal digit character, NO_DIGIT otherwise
    function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c inside {[CH_0:CH_9]}) begin
            d = c - CH_0;
        end else if (c inside {[CH_LA:CH_LF]}) begin
            d = c - CH_LA + 8'd10;
        end else if (c inside {[CH_UA:CH_UF]}) begin
            d = c - CH_UA + 8'd10;
        end else begin
            d = {3'b000, NO_DIGIT};
        end
        return d[RADIX_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/ascii_unsigned_number_parser_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ascii_unsigned_number_parser_unit
// Parses ASCII unsigned numbers (auto hex/decimal or a set radix), one
// character per transaction.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one character per transaction in tdata, tuser high on the
//   first character of a string. Master stream: one transaction per finished
//   parse, carrying the value and the offset of the first unconsumed char.
//   The radix register (0 = auto) is written through i_cfg_wr_en/data and is
//   sampled at each string's first character; the user must write it only while idle, unenforced by the block.
// Path: a character lands in the input register at its accept edge and is
//   parsed from there straight into the output register, which holds the
//   result; a stall on a terminating character can hold it in between.
// Throughput: one character per cycle while no held result stalls, bounded by
//   the accumulator loop (a 64 x 5 bit multiply-add feeding back each cycle).
// Reset: clears both stage valid bits, the parse state (idle phase, zero
//   accumulator, position and radix) and the radix register (auto mode).
// Stall: while a result waits on the master side, the input register still
//   parses characters that end no string; a character that ends one waits in
//   the input register and tready drops until the result is taken.
// ---------------------------------------------------------------------------
module ascii_unsigned_number_parser_unit
    import aunp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_wr_en,
    input  wire logic [RADIX_W-1:0] i_cfg_wr_data,  // radix_mode
    // slave stream
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [CHAR_W-1:0]  i_s_axis_tdata,  // [7:0] char_code
    input  wire logic               i_s_axis_tuser,  // [0] start_req
    // master stream
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [OUT_W-1:0]        o_m_axis_tdata   // [63:0] parsed_value,
                                                     // [79:64] end_offset
);

    // configuration register
    logic [RADIX_W-1:0] r_radix_mode;

    // input register
    logic               r_in_valid;
    logic               r_in_start;
    logic [CHAR_W-1:0]  r_in_char;

    // parse state
    t_phase             r_phase, n_phase;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [OFFSET_W-1:0] r_pos, n_pos;
    logic [RADIX_W-1:0] r_radix, n_radix;

    // output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [OFFSET_W-1:0] r_out_offset;

    // datapath signals
    logic               emit;
    logic [VALUE_W-1:0] n_out_value;
    logic [OFFSET_W-1:0] n_out_offset;
    logic               proc_fire;
    logic               proc_ok;
    logic [RADIX_W-1:0] dig;
    logic               is_zero_ch;
    logic               is_x_ch;
    logic               pfx_mode;
    logic [VALUE_W-1:0] base_acc;
    logic [OFFSET_W-1:0] base_pos;
    logic [RADIX_W-1:0] take_radix;
    logic               take_ok;
    logic [VALUE_W+RADIX_W-1:0] mul;
    logic [VALUE_W-1:0] take_acc;
    logic [OFFSET_W-1:0] take_pos;

    // ---------------- handshake ----------------
    // a character that ends a parse needs room in the output register
    assign proc_ok         = !emit || !r_out_valid || i_m_axis_tready;
    assign proc_fire       = r_in_valid && proc_ok;
    assign o_s_axis_tready = !r_in_valid || proc_ok;

    // ---------------- decode ----------------
    assign dig        = digit_of(r_in_char);
    assign is_zero_ch = (r_in_char == CH_0);
    assign is_x_ch    = (r_in_char == CH_LX) || (r_in_char == CH_UX);
    assign pfx_mode   = (r_radix_mode == RADIX_AUTO) || (r_radix_mode == RADIX_HEX);

    // operands of the digit step: fresh parses start from zero
    always_comb begin
        base_acc   = r_acc;
        base_pos   = r_pos;
        take_radix = r_radix;
        if (r_in_start) begin
            base_acc   = '0;
            base_pos   = '0;
            take_radix = (r_radix_mode == RADIX_AUTO) ? RADIX_DEC : r_radix_mode;
        end else if (r_phase == PH_ZERO) begin
            base_acc   = '0;
            take_radix = (r_radix == RADIX_AUTO) ? RADIX_DEC : r_radix;
        end
    end

    // digit step: acc * radix + digit, position bump with saturation
    assign take_ok  = (dig < take_radix);
    assign mul      = {{RADIX_W{1'b0}}, base_acc} * {{VALUE_W{1'b0}}, take_radix};
    assign take_acc = mul[VALUE_W-1:0] + {{(VALUE_W-RADIX_W){1'b0}}, dig};
    assign take_pos = (base_pos == OFFSET_MAX) ? base_pos : base_pos + 1'b1;

    // ---------------- next phase ----------------
    always_comb begin
        n_phase = r_phase;
        if (r_in_start) begin
            if (pfx_mode && is_zero_ch) begin
                n_phase = PH_ZERO;
            end else begin
                n_phase = take_ok ? PH_DIGITS : PH_IDLE;
            end
        end else begin
            case (r_phase)
                PH_DIGITS: n_phase = take_ok ? PH_DIGITS : PH_IDLE;
                PH_ZERO: begin
                    if (is_x_ch) begin
                        n_phase = PH_PREFIX;
                    end else begin
                        n_phase = take_ok ? PH_DIGITS : PH_IDLE;
                    end
                end
                PH_PREFIX: n_phase = (dig < RADIX_HEX) ? PH_DIGITS : PH_IDLE;
                default:   n_phase = PH_IDLE;
            endcase
        end
    end

    // ---------------- datapath and result ----------------
    always_comb begin
        n_acc        = r_acc;
        n_pos        = r_pos;
        n_radix      = r_radix;
        emit         = 1'b0;
        n_out_value  = base_acc;
        n_out_offset = base_pos;
        if (r_in_start) begin
            if (pfx_mode && is_zero_ch) begin
                n_acc   = '0;
                n_pos   = {{(OFFSET_W-1){1'b0}}, 1'b1};
                n_radix = r_radix_mode;
            end else begin
                n_radix = take_radix;
                n_acc   = take_ok ? take_acc : '0;
                n_pos   = take_ok ? take_pos : '0;
                emit    = !take_ok;
            end
        end else begin
            case (r_phase)
                PH_DIGITS: begin
                    if (take_ok) begin
                        n_acc = take_acc;
                        n_pos = take_pos;
                    end
                    emit = !take_ok;
                end
                PH_ZERO: begin
                    if (is_x_ch) begin
                        n_radix = RADIX_HEX;
                        n_pos   = 16'd2;
                    end else begin
                        n_radix = take_radix;
                        n_acc   = take_ok ? take_acc : '0;
                        n_pos   = take_ok ? take_pos : base_pos;
                        emit    = !take_ok;
                    end
                end
                PH_PREFIX: begin
                    // "0x" with no hex digit after it: only the zero counts
                    if (dig < RADIX_HEX) begin
                        n_acc = {{(VALUE_W-RADIX_W){1'b0}}, dig};
                        n_pos = 16'd3;
                    end else begin
                        emit         = 1'b1;
                        n_out_value  = '0;
                        n_out_offset = {{(OFFSET_W-1){1'b0}}, 1'b1};
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // ---------------- configuration register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_mode <= RADIX_MODE_RST;
        end else if (i_cfg_wr_en) begin
            r_radix_mode <= i_cfg_wr_data;
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_start <= i_s_axis_tuser;
            r_in_char  <= i_s_axis_tdata;
        end
    end

    // ---------------- parse state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_pos   <= '0;
            r_radix <= '0;
        end else if (proc_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_radix <= n_radix;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && emit) begin
            r_out_value  <= n_out_value;
            r_out_offset <= n_out_offset;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_offset, r_out_value};

    // ---------------- assertions ----------------
    // after "0x" the radix is always hex
    a_prefix_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PREFIX) |-> (r_radix == RADIX_HEX))
        else $error("prefix phase without hex radix");

    // a pending leading zero has consumed exactly one character, value zero
    a_zero_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ZERO) |-> ((r_pos == 16'd1) && (r_acc == '0)))
        else $error("leading-zero phase with bad position or value");

    // digit accumulation never runs in auto mode
    a_digit_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGITS) |-> (r_radix != RADIX_AUTO))
        else $error("digit phase with unresolved radix");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("pending result overwritten");

endmodule
`default_nettype wire
